>>> hw/rtl/ard_pkg.sv
package ard_pkg;

  // Frame geometry
  localparam int unsigned CountMax        = 63;
  localparam int unsigned HdrBytes        = 42;
  localparam int unsigned EthHdr          = 14;
  localparam int unsigned ReplyLength     = 60;
  localparam int unsigned MaxSlots        = 4;
  localparam int unsigned UnicastSlotsDef = 4;

  localparam int unsigned CountW  = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 48;

  // Header bytes that are kept: positions 12 to 31 and 38 to 41.
  localparam int unsigned CapBytes = 24;
  localparam int unsigned CapW     = 5;
  localparam int unsigned CapLoPos = 12;
  localparam int unsigned CapLoEnd = 31;
  localparam int unsigned CapHiPos = 38;
  localparam int unsigned CapHiEnd = 41;
  localparam int unsigned CapHiOff = 20;

  // Slots inside the kept bytes
  localparam int unsigned CapEthType = 0;
  localparam int unsigned CapArp     = 2;
  localparam int unsigned CapSha     = 10;
  localparam int unsigned CapTpa     = 20;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgOwnMac    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgExcPath   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgUniCount  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgUniAddr0  = 3'd3;

  typedef enum logic [1:0] {
    VerdictApp    = 2'd0,
    VerdictKernel = 2'd1,
    VerdictReply  = 2'd2
  } verdict_e;

  typedef logic [CapBytes-1:0][7:0] cap_t;

  // A finished frame waiting for its verdict
  typedef struct packed {
    logic              pend;
    logic [CountW-1:0] len;
  } eval_t;

  typedef struct packed {
    logic [47:0] own_mac;
    logic        exc_path;
    logic [2:0]  uni_count;
  } cfg_t;

  function automatic logic [7:0] mac_byte(logic [2:0] i, logic [47:0] mac);
    logic [7:0] r;
    r = '0;
    unique case (i)
      3'd0:    r = mac[47:40];
      3'd1:    r = mac[39:32];
      3'd2:    r = mac[31:24];
      3'd3:    r = mac[23:16];
      3'd4:    r = mac[15:8];
      3'd5:    r = mac[7:0];
      default: r = '0;
    endcase
    return r;
  endfunction

  // Byte idx of the ARP reply, built from the kept request bytes and own MAC.
  function automatic logic [7:0] reply_byte(logic [CountW-1:0] idx, cap_t cap,
                                            logic [47:0] mac);
    logic [7:0] r;
    r = '0;
    priority if (idx < 6'd6) begin
      r = cap[5'(idx) + 5'(CapSha)];
    end else if (idx < 6'd12) begin
      r = mac_byte(3'(idx - 6'd6), mac);
    end else if (idx == 6'd12) begin
      r = 8'h08;
    end else if (idx == 6'd13) begin
      r = 8'h06;
    end else if (idx < 6'd20) begin
      r = cap[5'(idx - 6'd12)];
    end else if (idx == 6'd20) begin
      r = 8'h00;
    end else if (idx == 6'd21) begin
      r = 8'h02;
    end else if (idx < 6'd28) begin
      r = mac_byte(3'(idx - 6'd22), mac);
    end else if (idx < 6'd32) begin
      r = cap[5'(idx - 6'd8)];
    end else if (idx < 6'd42) begin
      r = cap[5'(idx - 6'd22)];
    end else begin
      r = 8'h00;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/ard_capture.sv
module ard_capture (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          beat_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  input  logic          take_i,
  output ard_pkg::cap_t  cap_o,
  output ard_pkg::eval_t eval_o
);

  logic [ard_pkg::CountW-1:0] count_q, count_d;
  logic [ard_pkg::CountW-1:0] count_inc;
  logic [ard_pkg::CountW-1:0] len_q;
  logic                       pend_q, pend_d;
  logic                       hit;
  logic [ard_pkg::CapW-1:0]   slot;
  ard_pkg::cap_t              cap_q;

  assign count_inc = (count_q == 6'(ard_pkg::CountMax)) ? count_q : count_q + 6'd1;

  always_comb begin
    count_d = count_q;
    if (beat_i) begin
      count_d = last_i ? '0 : count_inc;
    end
    pend_d = (pend_q && !take_i) || (beat_i && last_i);
  end

  always_comb begin
    hit  = 1'b0;
    slot = '0;
    if (count_q >= 6'(ard_pkg::CapLoPos) && count_q <= 6'(ard_pkg::CapLoEnd)) begin
      hit  = 1'b1;
      slot = 5'(count_q - 6'(ard_pkg::CapLoPos));
    end else if (count_q >= 6'(ard_pkg::CapHiPos) && count_q <= 6'(ard_pkg::CapHiEnd)) begin
      hit  = 1'b1;
      slot = 5'(count_q - 6'(ard_pkg::CapHiPos)) + 5'(ard_pkg::CapHiOff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_i && last_i) begin
      len_q <= count_inc;
    end
    if (beat_i && hit) begin
      cap_q[slot] <= byte_i;
    end
  end

  assign cap_o       = cap_q;
  assign eval_o.pend = pend_q;
  assign eval_o.len  = len_q;

endmodule

>>> hw/rtl/ard_verdict.sv
module ard_verdict #(
  parameter int unsigned UnicastSlots = ard_pkg::UnicastSlotsDef
) (
  input  ard_pkg::eval_t              eval_i,
  input  ard_pkg::cap_t               cap_i,
  input  ard_pkg::cfg_t               cfg_i,
  input  logic [UnicastSlots-1:0][31:0] addr_i,
  output ard_pkg::verdict_e           verdict_o
);

  logic [31:0]             tpa;
  logic [UnicastSlots-1:0] slot_hit;
  logic                    is_request;

  assign tpa = {cap_i[ard_pkg::CapTpa], cap_i[ard_pkg::CapTpa + 1],
                cap_i[ard_pkg::CapTpa + 2], cap_i[ard_pkg::CapTpa + 3]};

  // Slots past the configured count never match; a count above the slot
  // number simply enables all of them.
  always_comb begin
    for (int i = 0; i < UnicastSlots; i++) begin
      slot_hit[i] = (3'(i) < cfg_i.uni_count) && (addr_i[i] == tpa);
    end
  end

  assign is_request = (cap_i[ard_pkg::CapEthType]     == 8'h08) &&
                      (cap_i[ard_pkg::CapEthType + 1] == 8'h06) &&
                      (cap_i[ard_pkg::CapArp]         == 8'h00) &&
                      (cap_i[ard_pkg::CapArp + 1]     == 8'h01) &&
                      (cap_i[ard_pkg::CapArp + 2]     == 8'h08) &&
                      (cap_i[ard_pkg::CapArp + 3]     == 8'h00) &&
                      (cap_i[ard_pkg::CapArp + 6]     == 8'h00) &&
                      (cap_i[ard_pkg::CapArp + 7]     == 8'h01);

  always_comb begin
    priority if (eval_i.len < 6'(ard_pkg::EthHdr)) begin
      verdict_o = ard_pkg::VerdictApp;
    end else if (cfg_i.exc_path) begin
      verdict_o = ard_pkg::VerdictKernel;
    end else if (eval_i.len >= 6'(ard_pkg::HdrBytes) && is_request && (|slot_hit)) begin
      verdict_o = ard_pkg::VerdictReply;
    end else begin
      verdict_o = ard_pkg::VerdictApp;
    end
  end

endmodule

>>> hw/rtl/ard_reply.sv
module ard_reply (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  ard_pkg::verdict_e verdict_i,
  input  ard_pkg::cap_t     cap_i,
  input  logic [47:0]       own_mac_i,
  input  logic              m_tready_i,
  output logic              m_tvalid_o,
  output logic [7:0]        m_tdata_o,
  output logic [1:0]        m_tuser_o,
  output logic              m_tlast_o,
  output logic              can_load_o,
  output logic              busy_o
);

  localparam logic [ard_pkg::CountW-1:0] LastIdx = 6'(ard_pkg::ReplyLength - 1);

  logic                       valid_q, valid_d;
  logic [7:0]                 data_q, data_d;
  ard_pkg::verdict_e          user_q, user_d;
  logic                       last_q, last_d;
  logic                       rep_q, rep_d;
  logic [ard_pkg::CountW-1:0] idx_q, idx_d;
  logic                       can_load;

  assign can_load = !valid_q || m_tready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    user_d  = user_q;
    last_d  = last_q;
    rep_d   = rep_q;
    idx_d   = idx_q;
    if (can_load) begin
      if (rep_q) begin
        valid_d = 1'b1;
        data_d  = ard_pkg::reply_byte(idx_q, cap_i, own_mac_i);
        user_d  = ard_pkg::VerdictReply;
        last_d  = (idx_q == LastIdx);
        rep_d   = (idx_q != LastIdx);
        idx_d   = idx_q + 6'd1;
      end else if (fire_i) begin
        valid_d = 1'b1;
        user_d  = verdict_i;
        if (verdict_i == ard_pkg::VerdictReply) begin
          data_d = ard_pkg::reply_byte('0, cap_i, own_mac_i);
          last_d = 1'b0;
          rep_d  = 1'b1;
          idx_d  = 6'd1;
        end else begin
          data_d = '0;
          last_d = 1'b1;
        end
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rep_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      rep_q   <= rep_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    user_q <= user_d;
    last_q <= last_d;
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = data_q;
  assign m_tuser_o  = user_q;
  assign m_tlast_o  = last_q;
  assign can_load_o = can_load;
  assign busy_o     = rep_q;

endmodule

>>> hw/rtl/arp_responder_frame_divert.sv
// ARP responder with frame diversion.
//
// Frame bytes enter on the s_axis channel, one byte per beat, tlast on the
// final byte. Bytes are taken every cycle that s_axis_tready_o is high. For
// each frame the m_axis channel gives one verdict beat (tuser 0 keep for the
// application, 1 send to the kernel, tdata zero, tlast set), or, with the
// exception path off, for an ARP request aimed at a configured unicast
// address, a 60-beat reply frame with tuser 2 and tlast on its final byte.
// A finished frame's verdict is held as pending until the output register
// is free, and is then loaded into it. During a reply burst, and while a
// verdict waits behind a stalled receiver, s_axis_tready_o is low. Otherwise,
// also between frames, the input keeps running at one byte per cycle.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i: 0 own
// MAC, 1 exception path, 2 unicast count, 3 and up the unicast IPv4 addresses.
// The user must write it only while the block is idle; the block itself
// does not enforce this. Reset clears the byte counter, the output valid
// flag, the reply sequencer and all configuration registers. When
// m_axis_tready_i is low the output beat holds its value until it is taken.
module arp_responder_frame_divert #(
  parameter int unsigned UnicastSlots = ard_pkg::UnicastSlotsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [7:0]                  s_axis_tdata_i,   // [7:0] frame_byte
  input  logic                        s_axis_tlast_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [7:0]                  m_axis_tdata_o,   // [7:0] reply_byte
  output logic [1:0]                  m_axis_tuser_o,   // [1:0] verdict
  output logic                        m_axis_tlast_o,
  input  logic                        cfg_we_i,
  input  logic [ard_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ard_pkg::CfgW-1:0]    cfg_wdata_i
);

  ard_pkg::cfg_t                 cfg_q;
  logic [UnicastSlots-1:0][31:0] addr_q;
  ard_pkg::cap_t                 cap;
  ard_pkg::eval_t                eval;
  ard_pkg::verdict_e             verdict;
  logic                          beat;
  logic                          fire;
  logic                          can_load;
  logic                          busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= '0;
      addr_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ard_pkg::CfgOwnMac) begin
        cfg_q.own_mac <= cfg_wdata_i[47:0];
      end
      if (cfg_idx_i == ard_pkg::CfgExcPath) begin
        cfg_q.exc_path <= cfg_wdata_i[0];
      end
      if (cfg_idx_i == ard_pkg::CfgUniCount) begin
        cfg_q.uni_count <= cfg_wdata_i[2:0];
      end
      for (int i = 0; i < UnicastSlots; i++) begin
        if (cfg_idx_i == ard_pkg::CfgUniAddr0 + 3'(i)) begin
          addr_q[i] <= cfg_wdata_i[31:0];
        end
      end
    end
  end

  // A pending verdict is taken as soon as the output register is free. The
  // first bytes of the next frame are never kept, so input may continue once it
  // is taken, unless a reply is starting, which still needs the kept bytes.
  assign fire            = eval.pend && can_load;
  assign s_axis_tready_o = !busy &&
                           !(eval.pend && (!can_load || verdict == ard_pkg::VerdictReply));
  assign beat            = s_axis_tvalid_i && s_axis_tready_o;

  ard_capture u_capture (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (beat),
    .byte_i (s_axis_tdata_i),
    .last_i (s_axis_tlast_i),
    .take_i (fire),
    .cap_o  (cap),
    .eval_o (eval)
  );

  ard_verdict #(
    .UnicastSlots (UnicastSlots)
  ) u_verdict (
    .eval_i    (eval),
    .cap_i     (cap),
    .cfg_i     (cfg_q),
    .addr_i    (addr_q),
    .verdict_o (verdict)
  );

  ard_reply u_reply (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .verdict_i  (verdict),
    .cap_i      (cap),
    .own_mac_i  (cfg_q.own_mac),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o),
    .can_load_o (can_load),
    .busy_o     (busy)
  );

endmodule

>>> hw/rtl/ard_checker.sv
module ard_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid_i,
  input logic                        s_axis_tready_o,
  input logic [7:0]                  s_axis_tdata_i,
  input logic                        s_axis_tlast_i,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [7:0]                  m_axis_tdata_o,
  input logic [1:0]                  m_axis_tuser_o,
  input logic                        m_axis_tlast_o,
  input logic                        cfg_we_i,
  input logic [ard_pkg::CfgIdxW-1:0] cfg_idx_i,
  input logic [ard_pkg::CfgW-1:0]    cfg_wdata_i
);

  // A stalled output beat stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output beat dropped while stalled");

  // A stalled output beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("output payload changed while stalled");

  // A plain verdict is a single beat with no data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != ard_pkg::VerdictReply |->
      m_axis_tlast_o && m_axis_tdata_o == 8'h00)
    else $error("verdict beat not a lone zero beat");

  // No frame byte is taken while a reply is still being sent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == ard_pkg::VerdictReply && !m_axis_tlast_o |->
      !s_axis_tready_o)
    else $error("input taken during a reply burst");

endmodule

bind arp_responder_frame_divert ard_checker u_ard_checker (.*);

>>> sim/ard_checker.sv
`timescale 1ns / 100ps

module ard_scoreboard
  import ard_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  input  logic               s_tready_i,
  input  logic [7:0]         s_tdata_i,
  input  logic               s_tlast_i,
  input  logic               m_tvalid_i,
  input  logic               m_tready_i,
  input  logic [7:0]         m_tdata_i,
  input  logic [1:0]         m_tuser_i,
  input  logic               m_tlast_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output int unsigned        miscompares_o,
  output int unsigned        outstanding_o
);

  localparam logic [15:0] EtherTypeArp  = 16'h0806;
  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [15:0] HwTypeEth     = 16'h0001;
  localparam logic [15:0] OpRequest     = 16'h0001;
  localparam logic [15:0] OpReply       = 16'h0002;

  typedef struct packed {
    verdict_e   verdict;
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  out_beat_t   outbound_q[$];
  out_beat_t   want;

  logic [CountW-1:0] frame_len;
  logic [7:0]        hdr [HdrBytes];
  logic [47:0]       own_mac;
  logic              exc_path;
  logic [2:0]        uni_count;
  logic [31:0]       uni_addr [MaxSlots];
  int                slot;

  task automatic note_miscompare(input string msg);
    miscompares_o++;
    if (miscompares_o <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic push_beat(input verdict_e v, input logic [7:0] d, input logic l);
    out_beat_t b;
    b.verdict = v;
    b.data    = d;
    b.last    = l;
    outbound_q.insert(outbound_q.size(), b);
  endtask

  function automatic logic target_hit();
    logic [31:0] tpa;
    int unsigned n;
    tpa = {hdr[38], hdr[39], hdr[40], hdr[41]};
    n = (uni_count > MaxSlots) ? MaxSlots : uni_count;
    for (int i = 0; i < n; i++) begin
      if (uni_addr[i] == tpa) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Bytes that do not close a frame only update the header store and the byte count.
  task automatic take_frame_byte(input logic [7:0] b, input logic l);
    int unsigned len;
    logic [7:0]  r [ReplyLength];
    if (frame_len < HdrBytes) hdr[frame_len] = b;
    if (frame_len < CountMax) frame_len++;
    if (!l) return;
    len = frame_len;
    frame_len = '0;
    if (len < EthHdr) begin
      push_beat(VerdictApp, 8'h00, 1'b1);
      return;
    end
    if (exc_path) begin
      push_beat(VerdictKernel, 8'h00, 1'b1);
      return;
    end
    if (len < HdrBytes || {hdr[12], hdr[13]} != EtherTypeArp ||
        {hdr[14], hdr[15]} != HwTypeEth || {hdr[16], hdr[17]} != EtherTypeIpv4 ||
        {hdr[20], hdr[21]} != OpRequest || !target_hit()) begin
      push_beat(VerdictApp, 8'h00, 1'b1);
      return;
    end
    for (int i = 0; i < ReplyLength; i++) r[i] = 8'h00;
    for (int i = 0; i < 6; i++) begin
      r[i]      = hdr[22 + i];
      r[6 + i]  = own_mac[47 - 8 * i -: 8];
      r[14 + i] = hdr[14 + i];
      r[22 + i] = own_mac[47 - 8 * i -: 8];
    end
    r[12] = EtherTypeArp[15:8];
    r[13] = EtherTypeArp[7:0];
    r[20] = OpReply[15:8];
    r[21] = OpReply[7:0];
    for (int i = 0; i < 4; i++) r[28 + i] = hdr[38 + i];
    for (int i = 0; i < 10; i++) r[32 + i] = hdr[22 + i];
    for (int i = 0; i < ReplyLength; i++) push_beat(VerdictReply, r[i], i == ReplyLength - 1);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len     = '0;
      own_mac       = '0;
      exc_path      = 1'b0;
      uni_count     = '0;
      foreach (uni_addr[i]) uni_addr[i] = '0;
      outbound_q.delete();
      miscompares_o = 0;
    end else begin
      // Results are checked before this edge's input is predicted; a verdict
      // can never leave in the cycle its last byte enters.
      if (m_tvalid_i && m_tready_i) begin
        if (outbound_q.size() == 0) begin
          note_miscompare($sformatf("output beat with nothing expected: verdict %0d data %02h last %0b",
                                    m_tuser_i, m_tdata_i, m_tlast_i));
        end else begin
          want = outbound_q.pop_front();
          if (m_tuser_i != want.verdict || m_tdata_i != want.data || m_tlast_i != want.last) begin
            note_miscompare($sformatf({"output beat mismatch: expected verdict %0d data %02h",
                                       " last %0b, got verdict %0d data %02h last %0b"},
                                      want.verdict, want.data, want.last,
                                      m_tuser_i, m_tdata_i, m_tlast_i));
          end
        end
      end
      if (cfg_we_i) begin
        slot = int'(cfg_idx_i) - int'(CfgUniAddr0);
        case (cfg_idx_i)
          CfgOwnMac:   own_mac   = cfg_wdata_i[47:0];
          CfgExcPath:  exc_path  = cfg_wdata_i[0];
          CfgUniCount: uni_count = cfg_wdata_i[2:0];
          default: begin
            if (slot >= 0 && slot < MaxSlots) uni_addr[slot] = cfg_wdata_i[31:0];
          end
        endcase
      end
      if (s_tvalid_i && s_tready_i) take_frame_byte(s_tdata_i, s_tlast_i);
    end
    outstanding_o = outbound_q.size();
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ard_pkg::*;

  localparam logic [15:0]        EtherTypeArp  = 16'h0806;
  localparam logic [15:0]        EtherTypeIpv4 = 16'h0800;
  localparam logic [15:0]        HwTypeEth     = 16'h0001;
  localparam logic [15:0]        OpRequest     = 16'h0001;
  localparam logic [15:0]        OpReply       = 16'h0002;
  localparam logic [CfgIdxW-1:0] CfgUnused     = 3'd7;

  typedef logic [7:0] byte_q_t[$];

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               s_tvalid  = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata   = '0;
  logic               s_tlast   = 1'b0;
  logic               m_tvalid;
  logic               m_tready  = 1'b0;
  logic [7:0]         m_tdata;
  logic [1:0]         m_tuser;
  logic               m_tlast;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx   = '0;
  logic [CfgW-1:0]    cfg_wdata = '0;
  int unsigned        miscompares;
  int unsigned        outstanding;

  int unsigned        src_idle  = 33;
  int unsigned        sink_idle = 59;
  logic [31:0]        cur_addr [MaxSlots] = '{default: '0};
  // Header bytes that decide whether a frame is an ARP request.
  int unsigned        checked_pos [8] = '{12, 13, 14, 15, 16, 17, 20, 21};

  arp_responder_frame_divert u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  ard_scoreboard u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .s_tlast_i     (s_tlast),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .m_tuser_i     (m_tuser),
    .m_tlast_i     (m_tlast),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .miscompares_o (miscompares),
    .outstanding_o (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle);
  end

  function automatic byte_q_t random_bytes(input int unsigned n);
    byte_q_t f;
    for (int i = 0; i < n; i++) f.insert(f.size(), 8'($urandom));
    return f;
  endfunction

  // Well-formed request of len bytes; shorter frames are cut from a full one.
  function automatic byte_q_t arp_request(input int unsigned len, input logic [31:0] tpa);
    byte_q_t f;
    f = random_bytes(len < HdrBytes ? HdrBytes : len);
    if ($urandom_range(1)) begin
      for (int i = 0; i < 6; i++) f[i] = 8'hFF;
    end
    f[12] = EtherTypeArp[15:8];
    f[13] = EtherTypeArp[7:0];
    f[14] = HwTypeEth[15:8];
    f[15] = HwTypeEth[7:0];
    f[16] = EtherTypeIpv4[15:8];
    f[17] = EtherTypeIpv4[7:0];
    f[18] = 8'd6;
    f[19] = 8'd4;
    f[20] = OpRequest[15:8];
    f[21] = OpRequest[7:0];
    for (int i = 0; i < 4; i++) f[38 + i] = tpa[31 - 8 * i -: 8];
    while (f.size() > len) void'(f.pop_back());
    return f;
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      s_tlast  <= 1'($urandom);
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_packet(input byte_q_t f);
    for (int i = 0; i < f.size(); i++) send_beat(f[i], i == f.size() - 1);
  endtask

  // Stops sending and waits until every expected beat has left the block.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
    if (idx >= CfgUniAddr0 && idx < CfgUniAddr0 + 3'(MaxSlots)) begin
      cur_addr[idx - CfgUniAddr0] = data[31:0];
    end
  endtask

  initial begin
    byte_q_t     f;
    int unsigned n, r, pick, frames, bytes;
    logic [31:0] tpa;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Narrow registers get random upper bits, which must be ignored.
    write_reg(CfgOwnMac, 48'hFFFF_FFFF_FFFF);
    write_reg(CfgExcPath, {47'($urandom), 1'b0});
    write_reg(CfgUniCount, {45'($urandom), 3'd4});
    write_reg(CfgUniAddr0, {16'($urandom), 32'h0000_0000});
    write_reg(CfgUniAddr0 + 3'd1, {16'($urandom), 32'hC0A8_0001});
    write_reg(CfgUniAddr0 + 3'd2, {16'($urandom), 32'h0A00_0005});
    write_reg(CfgUniAddr0 + 3'd3, {16'($urandom), 32'hFFFF_FFFF});

    send_packet(random_bytes(1));
    send_packet(random_bytes(13));
    send_packet(random_bytes(14));
    send_packet(arp_request(HdrBytes, cur_addr[0]));
    send_packet(arp_request(60, cur_addr[3]));
    send_packet(arp_request(HdrBytes - 1, cur_addr[1]));
    send_packet(arp_request(70, cur_addr[1]));
    f = arp_request(HdrBytes, cur_addr[2]);
    f[21] = OpReply[7:0];
    send_packet(f);
    f = arp_request(HdrBytes, cur_addr[2]);
    f[13] = EtherTypeIpv4[7:0];
    send_packet(f);
    f = arp_request(HdrBytes, cur_addr[2]);
    f[15] = 8'h06;
    send_packet(f);
    f = arp_request(HdrBytes, cur_addr[2]);
    f[16] = 8'h86;
    send_packet(f);
    send_packet(arp_request(HdrBytes, ~cur_addr[2]));

    drain();
    write_reg(CfgUnused, 48'({$urandom, $urandom}));
    write_reg(CfgUniCount, 48'd7);
    send_packet(arp_request(HdrBytes, cur_addr[3]));
    drain();
    write_reg(CfgUniCount, 48'd0);
    send_packet(arp_request(HdrBytes, cur_addr[0]));
    drain();
    write_reg(CfgUniCount, 48'd1);
    send_packet(arp_request(HdrBytes, cur_addr[1]));
    send_packet(arp_request(HdrBytes, cur_addr[0]));
    drain();
    write_reg(CfgExcPath, 48'd1);
    send_packet(random_bytes(5));
    send_packet(arp_request(HdrBytes, cur_addr[0]));
    send_packet(random_bytes(14));
    drain();
    write_reg(CfgOwnMac, 48'h0);
    write_reg(CfgExcPath, 48'd0);
    write_reg(CfgUniCount, 48'd4);
    send_packet(arp_request(HdrBytes, cur_addr[1]));

    for (int ph = 0; ph < 3; ph++) begin
      drain();
      src_idle  = (ph == 0) ? 33 : (ph == 1) ? 59 : 0;
      sink_idle = (ph == 0) ? 59 : (ph == 1) ? 33 : 0;
      write_reg(CfgOwnMac, 48'({$urandom, $urandom}));
      write_reg(CfgExcPath, 48'($urandom_range(3) == 0));
      write_reg(CfgUniCount, 48'($urandom_range(9) == 0 ? 0 : $urandom_range(1, 7)));
      for (int k = 0; k < MaxSlots; k++) begin
        write_reg(CfgUniAddr0 + 3'(k), 48'({$urandom, $urandom}));
      end
      frames = 0;
      bytes  = 0;
      while (frames < 16 && bytes < 84) begin
        pick = $urandom_range(99);
        tpa  = cur_addr[$urandom_range(MaxSlots - 1)];
        if (pick < 45) begin
          r = $urandom_range(99);
          n = (r < 60) ? HdrBytes : (r < 85) ? $urandom_range(43, 60) : $urandom_range(61, 80);
          if ($urandom_range(9) == 0) tpa = tpa ^ (32'd1 << $urandom_range(31));
          else if ($urandom_range(9) == 0) tpa = $urandom;
          f = arp_request(n, tpa);
        end else if (pick < 55) begin
          f = arp_request($urandom_range(HdrBytes, 50), tpa);
          n = checked_pos[$urandom_range(7)];
          f[n] = f[n] ^ 8'($urandom_range(1, 255));
        end else if (pick < 62) begin
          f = arp_request($urandom_range(EthHdr, HdrBytes - 1), tpa);
        end else if (pick < 77) begin
          f = random_bytes($urandom_range(1, EthHdr - 1));
        end else begin
          f = random_bytes($urandom_range(EthHdr, 70));
        end
        send_packet(f);
        bytes += f.size();
        frames++;
        if ($urandom_range(99) < 6) begin
          drain();
          n = $urandom_range(7);
          if (n == CfgUniCount) write_reg(CfgUniCount, 48'($urandom_range(7)));
          else write_reg(3'(n), 48'({$urandom, $urandom}));
        end
      end
    end

    drain();
    if (miscompares == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/ard_pkg.sv
hw/rtl/ard_capture.sv
hw/rtl/ard_verdict.sv
hw/rtl/ard_reply.sv
hw/rtl/arp_responder_frame_divert.sv
hw/rtl/ard_checker.sv
sim/ard_checker.sv
sim/tb_top.sv
